// ===== src/tmpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tmpt_pkg;

  localparam int TILE_COORD_BITS_DEF = 10;

  // Width of the scale operand (2W, W+S, 2H, H+S, LW all fit)
  localparam int MULT_B_BITS = 12;
  // Width of the signed addend (shift plus twice the draw offset)
  localparam int ADD_C_BITS  = 19;
  localparam int POS_BITS    = 24;
  localparam int ORDER_BITS  = 20;

  localparam logic [1:0] ORIENT_ORTHO = 2'd0;
  localparam logic [1:0] ORIENT_ISO   = 2'd1;
  localparam logic [1:0] ORIENT_HEX   = 2'd2;
  localparam logic [1:0] ORIENT_STAG  = 2'd3;

  localparam logic [2:0] REG_ORIENTATION  = 3'd0;
  localparam logic [2:0] REG_STAGGER_MODE = 3'd1;
  localparam logic [2:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_HEX_SIDE     = 3'd4;
  localparam logic [2:0] REG_LAYER_WIDTH  = 3'd5;
  localparam logic [2:0] REG_LAYER_HEIGHT = 3'd6;
  localparam logic [2:0] REG_DRAW_OFFSET  = 3'd7;

  localparam logic signed [POS_BITS-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_BITS-1:0] POS_MIN = 24'sh800000;

  typedef struct packed {
    logic [1:0]  orientation;
    logic [1:0]  stagger_mode;
    logic [9:0]  tile_width;
    logic [9:0]  tile_height;
    logic [9:0]  hex_side;
    logic [10:0] layer_width;
    logic [10:0] layer_height;
    logic [31:0] draw_offset;
  } cfg_t;

  // Signed width of the coordinate-derived multiplier operand
  function automatic int op_bits(input int cb);
    op_bits = ((cb > 11) ? cb : 11) + 3;
  endfunction

endpackage

`default_nettype wire

// ===== src/tmpt_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmpt_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output tmpt_pkg::cfg_t     cfg
);

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.orientation  <= tmpt_pkg::ORIENT_ORTHO;
      cfg.stagger_mode <= 2'd1;
      cfg.tile_width   <= 10'd32;
      cfg.tile_height  <= 10'd32;
      cfg.hex_side     <= 10'd0;
      cfg.layer_width  <= 11'd64;
      cfg.layer_height <= 11'd64;
      cfg.draw_offset  <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmpt_pkg::REG_ORIENTATION:  cfg.orientation  <= cfg_data[1:0];
        tmpt_pkg::REG_STAGGER_MODE: cfg.stagger_mode <= cfg_data[1:0];
        tmpt_pkg::REG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[9:0];
        tmpt_pkg::REG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[9:0];
        tmpt_pkg::REG_HEX_SIDE:     cfg.hex_side     <= cfg_data[9:0];
        tmpt_pkg::REG_LAYER_WIDTH:  cfg.layer_width  <= cfg_data[10:0];
        tmpt_pkg::REG_LAYER_HEIGHT: cfg.layer_height <= cfg_data[10:0];
        tmpt_pkg::REG_DRAW_OFFSET:  cfg.draw_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/tmpt_operands.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmpt_operands #(
  parameter int TILE_COORD_BITS = tmpt_pkg::TILE_COORD_BITS_DEF,
  localparam int FW = tmpt_pkg::op_bits(TILE_COORD_BITS),
  localparam int BW = tmpt_pkg::MULT_B_BITS,
  localparam int CW = tmpt_pkg::ADD_C_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [TILE_COORD_BITS-1:0]  tile_x,
  input  wire logic [TILE_COORD_BITS-1:0]  tile_y,
  input  wire tmpt_pkg::cfg_t              cfg,
  output logic                             op_valid,
  output logic signed [FW-1:0]             ax,
  output logic        [BW-1:0]             bx,
  output logic signed [CW-1:0]             cx,
  output logic signed [FW-1:0]             ay,
  output logic        [BW-1:0]             by,
  output logic signed [CW-1:0]             cy,
  output logic signed [FW-1:0]             az,
  output logic        [BW-1:0]             bz,
  output logic signed [CW-1:0]             cz,
  output logic                             oob
);

  localparam int CB = TILE_COORD_BITS;
  localparam logic signed [FW-1:0] ONE_F = FW'(1);
  localparam logic signed [FW-1:0] TWO_F = FW'(2);

  logic          v0;
  logic [CB-1:0] x0;
  logic [CB-1:0] y0;

  logic signed [FW-1:0] xs, ys, lws, lhs, r;
  logic        [BW-1:0] w2, h2, w1, h1, wps, hps, lwb;
  logic signed [CW-1:0] wc, hc, ox2, oy2, xc, xhalf, adj;
  logic        [11:0]   lw_up;
  logic                 axis_y, idx_even, x_odd, y_odd, hex_x;

  logic signed [FW-1:0] ax_next, ay_next;
  logic        [BW-1:0] bx_next, by_next;
  logic signed [CW-1:0] cx_next, cy_next, cz_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      op_valid <= 1'b0;
    end else begin
      v0       <= in_valid;
      op_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      x0 <= tile_x;
      y0 <= tile_y;
    end
  end

  always_comb begin
    xs  = signed'({{(FW-CB){1'b0}}, x0});
    ys  = signed'({{(FW-CB){1'b0}}, y0});
    lws = signed'({{(FW-11){1'b0}}, cfg.layer_width});
    lhs = signed'({{(FW-11){1'b0}}, cfg.layer_height});
    r   = lhs - ys - ONE_F;

    w1  = {2'b00, cfg.tile_width};
    h1  = {2'b00, cfg.tile_height};
    w2  = {1'b0, cfg.tile_width, 1'b0};
    h2  = {1'b0, cfg.tile_height, 1'b0};
    wps = w1 + {2'b00, cfg.hex_side};
    hps = h1 + {2'b00, cfg.hex_side};
    lwb = {1'b0, cfg.layer_width};

    wc  = signed'({{(CW-10){1'b0}}, cfg.tile_width});
    hc  = signed'({{(CW-10){1'b0}}, cfg.tile_height});
    ox2 = signed'({{(CW-17){cfg.draw_offset[15]}}, cfg.draw_offset[15:0], 1'b0});
    oy2 = signed'({{(CW-17){cfg.draw_offset[31]}}, cfg.draw_offset[31:16], 1'b0});
    xc  = signed'({{(CW-CB){1'b0}}, x0});
    xhalf = signed'({{(CW-CB){1'b0}}, x0 >> 1});

    axis_y   = cfg.stagger_mode[0];
    idx_even = cfg.stagger_mode[1];
    x_odd    = x0[0];
    y_odd    = y0[0];
    hex_x    = (cfg.orientation == tmpt_pkg::ORIENT_HEX) && !axis_y;

    ax_next = xs;
    bx_next = w2;
    cx_next = '0;
    ay_next = r;
    by_next = h2;
    cy_next = '0;

    case (cfg.orientation)
      tmpt_pkg::ORIENT_ORTHO: ;
      tmpt_pkg::ORIENT_ISO: begin
        ax_next = lws + xs - ys - ONE_F;
        bx_next = w1;
        ay_next = (lhs <<< 1) - xs - ys - TWO_F;
        by_next = h1;
      end
      tmpt_pkg::ORIENT_HEX: begin
        if (axis_y) begin
          cx_next = ox2 + (y_odd ? (idx_even ? -wc : wc) : '0);
          by_next = hps;
          cy_next = -oy2;
        end else begin
          bx_next = wps;
          cx_next = ox2;
          cy_next = (x_odd ? (idx_even ? hc : -hc) : '0) - oy2;
        end
      end
      default: begin
        cx_next = y_odd ? wc : '0;
        by_next = h1;
      end
    endcase

    lw_up = {1'b0, cfg.layer_width} + 12'd1;
    if (!idx_even) begin
      adj = x_odd ? signed'({{(CW-11){1'b0}}, lw_up[11:1]}) : '0;
    end else begin
      adj = x_odd ? '0 : signed'({{(CW-10){1'b0}}, cfg.layer_width[10:1]});
    end
    cz_next = hex_x ? (xhalf + adj) : xc;
  end

  always_ff @(posedge clk) begin
    if (v0) begin
      ax  <= ax_next;
      bx  <= bx_next;
      cx  <= cx_next;
      ay  <= ay_next;
      by  <= by_next;
      cy  <= cy_next;
      az  <= ys;
      bz  <= lwb;
      cz  <= cz_next;
      oob <= (xs >= lws) || (ys >= lhs);
    end
  end

endmodule

`default_nettype wire

// ===== src/tmpt_mul_add.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmpt_mul_add #(
  parameter int TILE_COORD_BITS = tmpt_pkg::TILE_COORD_BITS_DEF,
  localparam int FW = tmpt_pkg::op_bits(TILE_COORD_BITS),
  localparam int BW = tmpt_pkg::MULT_B_BITS,
  localparam int CW = tmpt_pkg::ADD_C_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       op_valid,
  input  wire logic signed [FW-1:0]       ax,
  input  wire logic        [BW-1:0]       bx,
  input  wire logic signed [CW-1:0]       cx,
  input  wire logic signed [FW-1:0]       ay,
  input  wire logic        [BW-1:0]       by,
  input  wire logic signed [CW-1:0]       cy,
  input  wire logic signed [FW-1:0]       az,
  input  wire logic        [BW-1:0]       bz,
  input  wire logic signed [CW-1:0]       cz,
  input  wire logic                       oob,
  output logic                            done,
  output logic signed [tmpt_pkg::POS_BITS-1:0] pixel_x_half,
  output logic signed [tmpt_pkg::POS_BITS-1:0] pixel_y_half,
  output logic [tmpt_pkg::ORDER_BITS-1:0] draw_order,
  output logic                            out_of_layer
);

  localparam int PW = FW + BW + 1;
  localparam int SW = PW + 1;

  logic                 v2;
  logic signed [PW-1:0] px, py, pz;
  logic signed [CW-1:0] cx2, cy2, cz2;
  logic                 oob2;
  logic signed [SW-1:0] sx, sy, sz;

  function automatic logic signed [tmpt_pkg::POS_BITS-1:0] sat(
    input logic signed [SW-1:0] v
  );
    if (v > SW'(tmpt_pkg::POS_MAX)) begin
      sat = tmpt_pkg::POS_MAX;
    end else if (v < SW'(tmpt_pkg::POS_MIN)) begin
      sat = tmpt_pkg::POS_MIN;
    end else begin
      sat = v[tmpt_pkg::POS_BITS-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v2   <= op_valid;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      px   <= PW'(ax) * signed'({{(PW-BW){1'b0}}, bx});
      py   <= PW'(ay) * signed'({{(PW-BW){1'b0}}, by});
      pz   <= PW'(az) * signed'({{(PW-BW){1'b0}}, bz});
      cx2  <= cx;
      cy2  <= cy;
      cz2  <= cz;
      oob2 <= oob;
    end
  end

  assign sx = SW'(px) + SW'(cx2);
  assign sy = SW'(py) + SW'(cy2);
  assign sz = SW'(pz) + SW'(cz2);

  always_ff @(posedge clk) begin
    if (v2) begin
      pixel_x_half <= sat(sx);
      pixel_y_half <= sat(sy);
      draw_order   <= sz[tmpt_pkg::ORDER_BITS-1:0];
      out_of_layer <= oob2;
    end
  end

endmodule

`default_nettype wire

// ===== src/tile_map_position_transform_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tile map position transform.
// Input: pulse start with tile_x/tile_y; the word is taken when start is high
// and busy is low. busy is high only during reset, so one coordinate can be
// issued every cycle.
// Output: done is high for one cycle with pixel_x_half, pixel_y_half (signed,
// half-pixel units, saturated to 24 bits), draw_order and out_of_layer.
// The receiver cannot stall; done follows start through the input register,
// operand register, product register and result register, in order,
// one result per coordinate, throughput one word per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 orientation,
// 1 stagger_mode, 2 tile_width, 3 tile_height, 4 hex_side, 5 layer_width,
// 6 layer_height, 7 draw_offset) and cfg_data; write only while idle.
// Reset: synchronous; drops all words in flight and restores the register
// defaults (orthogonal, 32x32 tiles, 64x64 layer).
module tile_map_position_transform_unit #(
  parameter int TILE_COORD_BITS = tmpt_pkg::TILE_COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [TILE_COORD_BITS-1:0]   tile_x,
  input  wire logic [TILE_COORD_BITS-1:0]   tile_y,
  output logic                              done,
  output logic signed [tmpt_pkg::POS_BITS-1:0] pixel_x_half,
  output logic signed [tmpt_pkg::POS_BITS-1:0] pixel_y_half,
  output logic [tmpt_pkg::ORDER_BITS-1:0]   draw_order,
  output logic                              out_of_layer,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [31:0]                  cfg_data
);

  localparam int FW = tmpt_pkg::op_bits(TILE_COORD_BITS);
  localparam int BW = tmpt_pkg::MULT_B_BITS;
  localparam int CW = tmpt_pkg::ADD_C_BITS;

  tmpt_pkg::cfg_t       cfg;
  logic                 op_valid;
  logic signed [FW-1:0] ax, ay, az;
  logic        [BW-1:0] bx, by, bz;
  logic signed [CW-1:0] cx, cy, cz;
  logic                 oob;

  assign busy = rst;

  tmpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tmpt_operands #(
    .TILE_COORD_BITS (TILE_COORD_BITS)
  ) u_ops (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .tile_x   (tile_x),
    .tile_y   (tile_y),
    .cfg      (cfg),
    .op_valid (op_valid),
    .ax       (ax),
    .bx       (bx),
    .cx       (cx),
    .ay       (ay),
    .by       (by),
    .cy       (cy),
    .az       (az),
    .bz       (bz),
    .cz       (cz),
    .oob      (oob)
  );

  tmpt_mul_add #(
    .TILE_COORD_BITS (TILE_COORD_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .ax           (ax),
    .bx           (bx),
    .cx           (cx),
    .ay           (ay),
    .by           (by),
    .cy           (cy),
    .az           (az),
    .bz           (bz),
    .cz           (cz),
    .oob          (oob),
    .done         (done),
    .pixel_x_half (pixel_x_half),
    .pixel_y_half (pixel_y_half),
    .draw_order   (draw_order),
    .out_of_layer (out_of_layer)
  );

endmodule

`default_nettype wire

// ===== src/tmpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmpt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic cfg_ready
);

  // every accepted word yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word produced no result");

  // no result without a matching accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without accepted word");

  // no stale result straight after reset
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result after reset");

  // configuration port always open and busy low outside reset
  a_cfg_open: assert property (@(posedge clk)
    !rst |-> (cfg_ready && !busy))
    else $error("port blocked outside reset");

endmodule

bind tile_map_position_transform_unit tmpt_checker u_tmpt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== sim/tile_map_position_transform_unit_tb.sv =====
`timescale 1ns / 1ps

module tile_map_position_transform_unit_tb;

  localparam int CB = tmpt_pkg::TILE_COORD_BITS_DEF;
  localparam int PB = tmpt_pkg::POS_BITS;
  localparam int OB = tmpt_pkg::ORDER_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [CB-1:0] tx;
    logic [CB-1:0] ty;
    logic signed [PB-1:0] px;
    logic signed [PB-1:0] py;
    logic [OB-1:0] order;
    logic oob;
  } tile_pos_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [CB-1:0] tile_x;
  logic [CB-1:0] tile_y;
  logic done;
  logic signed [PB-1:0] pixel_x_half;
  logic signed [PB-1:0] pixel_y_half;
  logic [OB-1:0] draw_order;
  logic out_of_layer;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  tmpt_pkg::cfg_t map_cfg;
  tile_pos_t expected_positions[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_mode = 0;

  tile_map_position_transform_unit #(.TILE_COORD_BITS(CB)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .tile_x(tile_x),
    .tile_y(tile_y),
    .done(done),
    .pixel_x_half(pixel_x_half),
    .pixel_y_half(pixel_y_half),
    .draw_order(draw_order),
    .out_of_layer(out_of_layer),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [PB-1:0] sat_pos(input longint v);
    if (v > tmpt_pkg::POS_MAX) return tmpt_pkg::POS_MAX;
    if (v < tmpt_pkg::POS_MIN) return tmpt_pkg::POS_MIN;
    return v[PB-1:0];
  endfunction

  function automatic tile_pos_t predict_tile(input logic [CB-1:0] tx, input logic [CB-1:0] ty);
    tile_pos_t res;
    longint x, y, w, h, s, lw, lh, ox, oy, r, px, py, z, shift, base;
    logic axis_y, idx_even;
    x = tx;
    y = ty;
    w = map_cfg.tile_width;
    h = map_cfg.tile_height;
    s = map_cfg.hex_side;
    lw = map_cfg.layer_width;
    lh = map_cfg.layer_height;
    ox = longint'($signed(map_cfg.draw_offset[15:0]));
    oy = longint'($signed(map_cfg.draw_offset[31:16]));
    r = lh - y - 1;
    axis_y = map_cfg.stagger_mode[0];
    idx_even = map_cfg.stagger_mode[1];
    case (map_cfg.orientation)
      tmpt_pkg::ORIENT_ORTHO: begin
        px = 2 * x * w;
        py = 2 * r * h;
      end
      tmpt_pkg::ORIENT_ISO: begin
        px = w * (lw + x - y - 1);
        py = h * (2 * lh - x - y - 2);
      end
      tmpt_pkg::ORIENT_HEX: begin
        if (axis_y) begin
          shift = y[0] ? (idx_even ? -w : w) : 0;
          px = 2 * x * w + shift + 2 * ox;
          py = r * (h + s) - 2 * oy;
        end else begin
          shift = x[0] ? (idx_even ? h : -h) : 0;
          px = x * (w + s) + 2 * ox;
          py = 2 * r * h + shift - 2 * oy;
        end
      end
      default: begin
        px = 2 * x * w + (y[0] ? w : 0);
        py = r * h;
      end
    endcase
    if (map_cfg.orientation == tmpt_pkg::ORIENT_HEX && !axis_y) begin
      base = x / 2 + y * lw;
      if (!idx_even) z = x[0] ? base + (lw + 1) / 2 : base;
      else z = x[0] ? base : base + lw / 2;
    end else begin
      z = x + y * lw;
    end
    res.tx = tx;
    res.ty = ty;
    res.px = sat_pos(px);
    res.py = sat_pos(py);
    res.order = z[OB-1:0];
    res.oob = (x >= lw) || (y >= lh);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    tile_pos_t want;
    if (!rst && done) begin
      if (expected_positions.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding x=%0d y=%0d",
                                  pixel_x_half, pixel_y_half));
      end else begin
        want = expected_positions.pop_front();
        if (pixel_x_half !== want.px)
          report_mismatch($sformatf("tile (%0d,%0d) pixel_x_half %0d, want %0d",
                                    want.tx, want.ty, pixel_x_half, want.px));
        if (pixel_y_half !== want.py)
          report_mismatch($sformatf("tile (%0d,%0d) pixel_y_half %0d, want %0d",
                                    want.tx, want.ty, pixel_y_half, want.py));
        if (draw_order !== want.order)
          report_mismatch($sformatf("tile (%0d,%0d) draw_order %0d, want %0d",
                                    want.tx, want.ty, draw_order, want.order));
        if (out_of_layer !== want.oob)
          report_mismatch($sformatf("tile (%0d,%0d) out_of_layer %0b, want %0b",
                                    want.tx, want.ty, out_of_layer, want.oob));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // start stays high into the next call when no gap is drawn
  task automatic send_tile(input logic [CB-1:0] tx, input logic [CB-1:0] ty);
    int gap;
    gap = (gap_mode == 0) ? 0 : ((gap_mode == 1) ? $urandom_range(0, 17)
                                 : (($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0));
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    tile_x = tx;
    tile_y = ty;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_positions = {expected_positions, predict_tile(tx, ty)};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tmpt_pkg::REG_ORIENTATION:  map_cfg.orientation = data[1:0];
      tmpt_pkg::REG_STAGGER_MODE: map_cfg.stagger_mode = data[1:0];
      tmpt_pkg::REG_TILE_WIDTH:   map_cfg.tile_width = data[9:0];
      tmpt_pkg::REG_TILE_HEIGHT:  map_cfg.tile_height = data[9:0];
      tmpt_pkg::REG_HEX_SIDE:     map_cfg.hex_side = data[9:0];
      tmpt_pkg::REG_LAYER_WIDTH:  map_cfg.layer_width = data[10:0];
      tmpt_pkg::REG_LAYER_HEIGHT: map_cfg.layer_height = data[10:0];
      tmpt_pkg::REG_DRAW_OFFSET:  map_cfg.draw_offset = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_map_config(input logic [31:0] orient, input logic [31:0] mode,
                                  input logic [31:0] w, input logic [31:0] h,
                                  input logic [31:0] side, input logic [31:0] lw,
                                  input logic [31:0] lh, input logic [31:0] offset);
    wait_drained();
    write_reg(tmpt_pkg::REG_ORIENTATION, orient);
    write_reg(tmpt_pkg::REG_STAGGER_MODE, mode);
    write_reg(tmpt_pkg::REG_TILE_WIDTH, w);
    write_reg(tmpt_pkg::REG_TILE_HEIGHT, h);
    write_reg(tmpt_pkg::REG_HEX_SIDE, side);
    write_reg(tmpt_pkg::REG_LAYER_WIDTH, lw);
    write_reg(tmpt_pkg::REG_LAYER_HEIGHT, lh);
    write_reg(tmpt_pkg::REG_DRAW_OFFSET, offset);
  endtask

  task automatic test_reset_defaults();
    gap_mode = 0;
    send_tile(0, 0);
    send_tile(63, 63);
    send_tile(64, 0);
    send_tile(1023, 1023);
  endtask

  task automatic test_orthogonal_extremes();
    apply_map_config(32'(tmpt_pkg::ORIENT_ORTHO), 0, 1023, 1023, 0, 1024, 1024, 0);
    send_tile(1023, 1023);
    send_tile(0, 0);
    send_tile(1023, 0);
  endtask

  task automatic test_zero_and_oversized();
    apply_map_config(32'(tmpt_pkg::ORIENT_ORTHO), 0, 0, 0, 0, 0, 0, 0);
    send_tile(5, 5);
    // upper data bits dropped: layer becomes 2047 x 2047
    apply_map_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tile(1023, 1023);
    send_tile(0, 0);
  endtask

  task automatic test_isometric();
    apply_map_config(32'(tmpt_pkg::ORIENT_ISO), 0, 1023, 1023, 0, 1024, 1, 0);
    send_tile(0, 1023);
    send_tile(1023, 0);
  endtask

  task automatic test_hexagonal_modes();
    for (int m = 0; m < 4; m++) begin
      apply_map_config(32'(tmpt_pkg::ORIENT_HEX), m, 1023, 1023, 1023, 1023, 1024,
                       (m < 2) ? 32'h8000_7FFF : 32'h7FFF_8000);
      send_tile(1, 1);
      send_tile(2, 2);
    end
  endtask

  task automatic test_staggered();
    apply_map_config(32'(tmpt_pkg::ORIENT_STAG), 0, 1023, 1023, 0, 1024, 1024, 0);
    send_tile(0, 1);
    send_tile(1, 0);
    send_tile(1023, 1023);
  endtask

  function automatic logic [10:0] pick_dim(input int max_val);
    case ($urandom_range(0, 11))
      0: return 11'd1;
      1: return 11'(max_val);
      2: return 11'd0;
      3: return (max_val > 1023) ? 11'd2047 : 11'(max_val);
      default: return 11'($urandom_range(1, max_val));
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_coord(input logic [10:0] lim);
    int top;
    top = (lim > 1024) ? 1024 : int'(lim);
    case ($urandom_range(0, 9))
      0: return CB'($urandom_range(0, 1023));
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return (top > 0) ? CB'(top - 1) : '0;
          default: return CB'(top);
        endcase
      end
      default: return (top == 0) ? CB'($urandom_range(0, 1023)) : CB'($urandom_range(0, top - 1));
    endcase
  endfunction

  task automatic test_random_traffic(input int n_items);
    int sent;
    int phase;
    int phase_len;
    logic [31:0] d [8];
    sent = 0;
    phase = 0;
    while (sent < n_items) begin
      for (int i = 0; i < 8; i++) d[i] = $urandom;
      d[0][1:0] = 2'(phase % 4);
      d[2][9:0] = 10'(pick_dim(1023));
      d[3][9:0] = 10'(pick_dim(1023));
      d[4][9:0] = 10'(pick_dim(1023));
      d[5][10:0] = pick_dim(1024);
      d[6][10:0] = pick_dim(1024);
      apply_map_config(d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7]);
      gap_mode = $urandom_range(0, 2);
      phase_len = $urandom_range(60, 140);
      for (int k = 0; k < phase_len && sent < n_items; k++) begin
        if (k == phase_len / 2 && phase % 3 == 1) wait_drained();
        send_tile(pick_coord(map_cfg.layer_width), pick_coord(map_cfg.layer_height));
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    tile_x = '0;
    tile_y = '0;
    cfg_valid = 1'b0;
    cfg_index = tmpt_pkg::REG_ORIENTATION;
    cfg_data = '0;
    map_cfg.orientation = tmpt_pkg::ORIENT_ORTHO;
    map_cfg.stagger_mode = 2'd1;
    map_cfg.tile_width = 10'd32;
    map_cfg.tile_height = 10'd32;
    map_cfg.hex_side = 10'd0;
    map_cfg.layer_width = 11'd64;
    map_cfg.layer_height = 11'd64;
    map_cfg.draw_offset = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_orthogonal_extremes();
    test_zero_and_oversized();
    test_isometric();
    test_hexagonal_modes();
    test_staggered();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tmpt_pkg.sv
src/tmpt_cfg_regs.sv
src/tmpt_operands.sv
src/tmpt_mul_add.sv
src/tile_map_position_transform_unit.sv
src/tmpt_checker.sv
sim/tile_map_position_transform_unit_tb.sv
